/* rtl/core/bcdt_pkg.sv */
// Shared types, constants and helper functions for the BCD countdown timer.
// No dependencies; every other file of the block uses this package.
package bcdt_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_W    = 4;
    localparam int PRE_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TENTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TENTHS_PER_HALF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALVES_PER_SECOND = 2'd2;

    // Reset values of the prescaler registers and counters
    localparam logic [PRE_W-1:0] TICKS_RESET  = 8'd100;
    localparam logic [PRE_W-1:0] TENTHS_RESET = 8'd5;
    localparam logic [PRE_W-1:0] HALVES_RESET = 8'd2;

    localparam logic [7:0] SEG_DP     = 8'b1000_0000;
    localparam logic [1:0] DP_POS     = 2'd2;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    typedef enum logic [1:0] {
        MODE_CONFIG   = 2'd0,
        MODE_PAUSED   = 2'd1,
        MODE_COUNTING = 2'd2,
        MODE_ALARM    = 2'd3
    } t_mode;

    // Element 0 is the thousands digit, element 3 the ones digit
    typedef logic [3:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic [PRE_W-1:0] ticks_per_tenth;
        logic [PRE_W-1:0] tenths_per_half;
        logic [PRE_W-1:0] halves_per_second;
    } t_cfg;

    typedef struct packed {
        logic half;
        logic second;
    } t_pre_evt;

    typedef struct packed {
        logic [3:0] digit_enable;
        logic [7:0] segments;
        logic       buzzer;
        t_mode      mode;
        t_digits    digits;
    } t_result;

    function automatic logic [7:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Ripple increment from the ones digit; digits at 9 or above wrap to 0
    function automatic t_digits bcd_inc(input t_digits v);
        t_digits r;
        logic    carry;
        r     = v;
        carry = 1'b1;
        for (int i = 3; i >= 0; i--) begin
            if (carry) begin
                if (v[i] >= DIGIT_MAX) begin
                    r[i] = '0;
                end else begin
                    r[i]  = v[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic t_digits bcd_dec(input t_digits v);
        t_digits r;
        logic    borrow;
        r      = v;
        borrow = 1'b1;
        for (int i = 3; i >= 0; i--) begin
            if (borrow) begin
                if (v[i] == '0) begin
                    r[i] = DIGIT_MAX;
                end else begin
                    r[i]   = v[i] - 4'd1;
                    borrow = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/bcdt_if.sv */
// Handshake channel interfaces: tick input, result output, register writes.
// Depends on bcdt_pkg for widths.
interface bcdt_in_if;
    logic valid;
    logic ready;
    logic start_level;
    logic clear_level;
    logic up_level;
    logic down_level;
    modport source (output valid, start_level, clear_level, up_level, down_level,
                    input ready);
    modport sink   (input valid, start_level, clear_level, up_level, down_level,
                    output ready);
endinterface

interface bcdt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit_enable;
    logic [7:0] segments;
    logic       buzzer;
    logic [1:0] mode;
    logic [3:0] count_thousands;
    logic [3:0] count_hundreds;
    logic [3:0] count_tens;
    logic [3:0] count_ones;
    modport source (output valid, digit_enable, segments, buzzer, mode,
                    count_thousands, count_hundreds, count_tens, count_ones,
                    input ready);
    modport sink   (input valid, digit_enable, segments, buzzer, mode,
                    count_thousands, count_hundreds, count_tens, count_ones,
                    output ready);
endinterface

interface bcdt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bcdt_pkg::CFG_IDX_W-1:0] index;
    logic [bcdt_pkg::PRE_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/bcdt_prescaler.sv */
// Millisecond prescaler chain: counts ticks into tenths and gives half-second and one-second events.
// Depends on bcdt_pkg.
module bcdt_prescaler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  bcdt_pkg::t_cfg     i_cfg,
    output bcdt_pkg::t_pre_evt o_evt
);

    logic [bcdt_pkg::PRE_W-1:0] r_tick, r_tenth, r_half;
    logic [bcdt_pkg::PRE_W-1:0] n_tick, n_tenth, n_half;

    always_comb begin
        n_tick       = r_tick - 8'd1;
        n_tenth      = r_tenth;
        n_half       = r_half;
        o_evt.half   = 1'b0;
        o_evt.second = 1'b0;
        if (n_tick == '0) begin
            n_tick  = i_cfg.ticks_per_tenth;
            n_tenth = r_tenth - 8'd1;
            if (n_tenth == '0) begin
                n_tenth    = i_cfg.tenths_per_half;
                o_evt.half = 1'b1;
                n_half     = r_half - 8'd1;
                if (n_half == '0) begin
                    n_half       = i_cfg.halves_per_second;
                    o_evt.second = 1'b1;
                end
            end
        end
        // events only count on an accepted tick
        o_evt.half   = o_evt.half & i_step;
        o_evt.second = o_evt.second & i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= bcdt_pkg::TICKS_RESET;
            r_tenth <= bcdt_pkg::TENTHS_RESET;
            r_half  <= bcdt_pkg::HALVES_RESET;
        end else if (i_step) begin
            r_tick  <= n_tick;
            r_tenth <= n_tenth;
            r_half  <= n_half;
        end
    end

endmodule

/* rtl/core/bcdt_display.sv */
// Display scan: one digit strobe and segment pattern per tick.
// Depends on bcdt_pkg.
module bcdt_display (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  bcdt_pkg::t_digits i_digits,
    output logic [3:0]        o_digit_enable,
    output logic [7:0]        o_segments
);

    logic [1:0] r_scan;
    logic [1:0] n_scan;
    logic [3:0] pos_inc;

    assign pos_inc = {2'b00, r_scan} + 4'd1;

    always_comb begin
        o_digit_enable = 4'b1000 >> r_scan;
        o_segments     = bcdt_pkg::seg_decode(i_digits[r_scan]);
        if (r_scan == bcdt_pkg::DP_POS) begin
            o_segments = o_segments | bcdt_pkg::SEG_DP;
        end
        if (pos_inc >= 4'(bcdt_pkg::NUM_DIGITS) || r_scan == 2'd3) begin
            n_scan = 2'd0;
        end else begin
            n_scan = pos_inc[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= 2'd0;
        end else if (i_step) begin
            r_scan <= n_scan;
        end
    end

endmodule

/* rtl/core/bcdt_mode_ctrl.sv */
// Mode controller: configure, paused, counting and alarm, plus the BCD value.
// Depends on bcdt_pkg.
module bcdt_mode_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_start,
    input  logic               i_clear,
    input  logic               i_up,
    input  logic               i_down,
    input  bcdt_pkg::t_pre_evt i_evt,
    output bcdt_pkg::t_digits  o_digits,
    output bcdt_pkg::t_mode    o_next_mode,
    output bcdt_pkg::t_digits  o_next_digits
);

    bcdt_pkg::t_mode   r_mode, n_mode;
    bcdt_pkg::t_digits r_digits, n_digits;
    logic r_half_flag, n_half_flag;
    logic r_sec_flag, n_sec_flag;
    logic r_prev_start, r_prev_clear;
    logic start_edge, clear_edge;
    logic is_zero, is_max;

    assign start_edge = i_start & ~r_prev_start;
    assign clear_edge = i_clear & ~r_prev_clear;

    always_comb begin
        n_mode      = r_mode;
        n_digits    = r_digits;
        n_half_flag = r_half_flag | i_evt.half;
        n_sec_flag  = r_sec_flag | i_evt.second;
        is_zero     = 1'b0;
        is_max      = 1'b0;
        case (r_mode)
            bcdt_pkg::MODE_CONFIG: begin
                if (start_edge && (r_digits != '0)) begin
                    n_mode = bcdt_pkg::MODE_COUNTING;
                end
                is_max = (n_digits == {4{bcdt_pkg::DIGIT_MAX}});
                if (i_up && !is_max && n_half_flag) begin
                    n_half_flag = 1'b0;
                    n_digits    = bcdt_pkg::bcd_inc(n_digits);
                end
                // down sees the value left by the up step
                is_zero = (n_digits == '0);
                if (i_down && !is_zero && n_half_flag) begin
                    n_half_flag = 1'b0;
                    n_digits    = bcdt_pkg::bcd_dec(n_digits);
                end
            end
            bcdt_pkg::MODE_PAUSED: begin
                if (start_edge) begin
                    n_mode = bcdt_pkg::MODE_COUNTING;
                end
                if (clear_edge) begin
                    n_digits = '0;
                    n_mode   = bcdt_pkg::MODE_CONFIG;
                end
            end
            bcdt_pkg::MODE_COUNTING: begin
                if (n_sec_flag) begin
                    n_sec_flag = 1'b0;
                    if (r_digits != '0) begin
                        n_digits = bcdt_pkg::bcd_dec(r_digits);
                    end else begin
                        n_mode = bcdt_pkg::MODE_ALARM;
                    end
                end
                if (start_edge) begin
                    n_mode = bcdt_pkg::MODE_PAUSED;
                end
            end
            default: begin
                if (clear_edge) begin
                    n_mode = bcdt_pkg::MODE_CONFIG;
                end
            end
        endcase
    end

    assign o_digits      = r_digits;
    assign o_next_mode   = n_mode;
    assign o_next_digits = n_digits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= bcdt_pkg::MODE_CONFIG;
            r_digits     <= '0;
            r_half_flag  <= 1'b0;
            r_sec_flag   <= 1'b0;
            r_prev_start <= 1'b0;
            r_prev_clear <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_digits     <= n_digits;
            r_half_flag  <= n_half_flag;
            r_sec_flag   <= n_sec_flag;
            r_prev_start <= i_start;
            r_prev_clear <= i_clear;
        end
    end

endmodule

/* rtl/core/bcdt_out_buf.sv */
// Result register with a skid entry, so a tick is taken while a result waits.
// Depends on bcdt_pkg and bcdt_out_if.
module bcdt_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bcdt_pkg::t_result i_data,
    output logic              o_ready,
    bcdt_out_if.source        o_out
);

    bcdt_pkg::t_result r_out, n_out, r_skid, n_skid;
    logic r_out_v, n_out_v, r_skid_v, n_skid_v;
    logic pop;

    assign pop     = r_out_v & o_out.ready;
    assign o_ready = ~r_skid_v;

    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v;
        n_skid   = r_skid;
        n_skid_v = r_skid_v;
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_out_v  = 1'b1;
                n_skid_v = 1'b0;
            end else begin
                n_out   = i_data;
                n_out_v = i_push;
            end
        end else if (i_push) begin
            n_skid   = i_data;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid           = r_out_v;
    assign o_out.digit_enable    = r_out.digit_enable;
    assign o_out.segments        = r_out.segments;
    assign o_out.buzzer          = r_out.buzzer;
    assign o_out.mode            = r_out.mode;
    assign o_out.count_thousands = r_out.digits[0];
    assign o_out.count_hundreds  = r_out.digits[1];
    assign o_out.count_tens      = r_out.digits[2];
    assign o_out.count_ones      = r_out.digits[3];

endmodule

/* rtl/core/bcd_countdown_timer_display.sv */
// Countdown timer with four BCD digits and a multiplexed seven-segment scan.
// An accepted tick's result is registered in the result register, or in the skid entry.
// Throughput: one tick per cycle while the skid entry is empty; all per-tick work is one pass of logic into
//   the state registers and the result register, and a skid entry keeps i_in
//   open for one more tick while a result waits.
// Reset: synchronous, active low; configure mode, value 0000, prescaler reloaded.
// Depends on bcdt_pkg, bcdt_if, bcdt_prescaler, bcdt_display, bcdt_mode_ctrl,
// bcdt_out_buf.
module bcd_countdown_timer_display (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bcdt_in_if.sink    i_in,
    bcdt_cfg_if.sink   i_cfg,
    bcdt_out_if.source o_out
);

    // Prescaler period registers; new values are picked up at the next reload
    bcdt_pkg::t_cfg     r_cfg;
    bcdt_pkg::t_pre_evt pre_evt;
    bcdt_pkg::t_digits  cur_digits, next_digits;
    bcdt_pkg::t_mode    next_mode;
    bcdt_pkg::t_result  result;
    logic               step;
    logic               buf_ready;
    logic [3:0]         digit_enable;
    logic [7:0]         segments;

    // A beat on i_in is one millisecond tick
    assign i_in.ready = buf_ready;
    assign step       = i_in.valid & buf_ready;

    // Register writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_tenth   <= bcdt_pkg::TICKS_RESET;
            r_cfg.tenths_per_half   <= bcdt_pkg::TENTHS_RESET;
            r_cfg.halves_per_second <= bcdt_pkg::HALVES_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bcdt_pkg::REG_TICKS_PER_TENTH:   r_cfg.ticks_per_tenth   <= i_cfg.data;
                bcdt_pkg::REG_TENTHS_PER_HALF:   r_cfg.tenths_per_half   <= i_cfg.data;
                bcdt_pkg::REG_HALVES_PER_SECOND: r_cfg.halves_per_second <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Prescaler steps first in a tick; its events feed the mode logic
    bcdt_prescaler u_prescaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .o_evt   (pre_evt)
    );

    // The display shows the value held before this tick's mode update
    bcdt_display u_display (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_digits       (cur_digits),
        .o_digit_enable (digit_enable),
        .o_segments     (segments)
    );

    bcdt_mode_ctrl u_mode_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_start       (i_in.start_level),
        .i_clear       (i_in.clear_level),
        .i_up          (i_in.up_level),
        .i_down        (i_in.down_level),
        .i_evt         (pre_evt),
        .o_digits      (cur_digits),
        .o_next_mode   (next_mode),
        .o_next_digits (next_digits)
    );

    // Result carries the mode and value after this tick
    always_comb begin
        result.digit_enable = digit_enable;
        result.segments     = segments;
        result.buzzer       = (next_mode == bcdt_pkg::MODE_ALARM);
        result.mode         = next_mode;
        result.digits       = next_digits;
    end

    bcdt_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_out   (o_out)
    );

    // Buzzer and mode code must agree on every result
    a_buzzer_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.buzzer == (o_out.mode == bcdt_pkg::MODE_ALARM)))
        else $error("buzzer does not match alarm mode");

    // Input only backs up when a result is already waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid)
        else $error("input stalled with no result pending");

    // Exactly one digit is strobed per result
    a_strobe_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot(o_out.digit_enable))
        else $error("digit strobe not one-hot");

    // After an accepted tick o_out.valid is always high on the next cycle, though it may carry an older result
    a_tick_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out.valid)
        else $error("accepted tick produced no result");

endmodule

/* sim/bcdt_timer_checker.sv */
// Scoreboard for the BCD countdown timer: keeps its own copy of the prescaler,
// mode logic and display scan, and compares every result beat field by field.
// Depends on bcdt_pkg and the channel interfaces in bcdt_if.
module bcdt_timer_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bcdt_in_if   i_tick,
    bcdt_cfg_if  i_reg,
    bcdt_out_if  i_disp,
    output int   o_fail_count,
    output int   o_pending
);

    // segment patterns for 0..9, index 0 leftmost
    localparam logic [0:9][7:0] GLYPH = {
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct packed {
        logic [3:0]      strobe;
        logic [7:0]      seg;
        logic            buzz;
        bcdt_pkg::t_mode mode;
        logic [3:0]      thou;
        logic [3:0]      hund;
        logic [3:0]      tens;
        logic [3:0]      ones;
    } t_frame;

    logic [bcdt_pkg::PRE_W-1:0] ticks_reload, tenths_reload, halves_reload;
    logic [bcdt_pkg::PRE_W-1:0] tick_cnt, tenth_cnt, half_cnt;
    logic                       half_due, second_due;
    bcdt_pkg::t_mode            mode_now;
    logic [3:0]                 digit_val [4];     // [0] thousands .. [3] ones
    logic [1:0]                 scan_pos;
    logic                       start_was, clear_was;
    t_frame                     frames_due [$];
    int                         errors = 0;

    function automatic logic value_is_zero();
        return (digit_val[0] | digit_val[1] | digit_val[2] | digit_val[3]) == 4'd0;
    endfunction

    function automatic logic value_is_max();
        return digit_val[0] == bcdt_pkg::DIGIT_MAX && digit_val[1] == bcdt_pkg::DIGIT_MAX &&
               digit_val[2] == bcdt_pkg::DIGIT_MAX && digit_val[3] == bcdt_pkg::DIGIT_MAX;
    endfunction

    task automatic step_down();
        logic borrow;
        borrow = 1'b1;
        for (int i = 3; i >= 0; i--) begin
            if (borrow) begin
                if (digit_val[i] == 4'd0) begin
                    digit_val[i] = bcdt_pkg::DIGIT_MAX;
                end else begin
                    digit_val[i] = digit_val[i] - 4'd1;
                    borrow = 1'b0;
                end
            end
        end
    endtask

    // one millisecond tick: prescaler, then display, then mode logic
    task automatic tick_timer(input logic st, input logic cl, input logic up,
                              input logic dn, output t_frame f);
        logic       st_edge, cl_edge, carry;
        logic [1:0] pos;
        st_edge = st && !start_was;
        cl_edge = cl && !clear_was;

        tick_cnt = tick_cnt - 8'd1;
        if (tick_cnt == 8'd0) begin
            tick_cnt  = ticks_reload;
            tenth_cnt = tenth_cnt - 8'd1;
            if (tenth_cnt == 8'd0) begin
                tenth_cnt = tenths_reload;
                half_due  = 1'b1;
                half_cnt  = half_cnt - 8'd1;
                if (half_cnt == 8'd0) begin
                    half_cnt   = halves_reload;
                    second_due = 1'b1;
                end
            end
        end

        // display uses the value from before this tick's mode logic
        pos      = scan_pos;
        f.strobe = 4'b1000 >> pos;
        f.seg    = GLYPH[digit_val[pos]];
        if (pos == bcdt_pkg::DP_POS) f.seg = f.seg | bcdt_pkg::SEG_DP;
        scan_pos = (int'(pos) + 1 >= bcdt_pkg::NUM_DIGITS || pos == 2'd3) ? 2'd0 : pos + 2'd1;

        case (mode_now)
            bcdt_pkg::MODE_CONFIG: begin
                if (st_edge && !value_is_zero()) mode_now = bcdt_pkg::MODE_COUNTING;
                if (up && half_due && !value_is_max()) begin
                    half_due = 1'b0;
                    carry    = 1'b1;
                    for (int i = 3; i >= 0; i--) begin
                        if (carry) begin
                            if (digit_val[i] >= bcdt_pkg::DIGIT_MAX) begin
                                digit_val[i] = 4'd0;
                            end else begin
                                digit_val[i] = digit_val[i] + 4'd1;
                                carry = 1'b0;
                            end
                        end
                    end
                end
                // up already took the flag if it moved the value
                if (dn && half_due && !value_is_zero()) begin
                    half_due = 1'b0;
                    step_down();
                end
            end
            bcdt_pkg::MODE_PAUSED: begin
                if (st_edge) mode_now = bcdt_pkg::MODE_COUNTING;
                if (cl_edge) begin
                    for (int i = 0; i < 4; i++) digit_val[i] = 4'd0;
                    mode_now = bcdt_pkg::MODE_CONFIG;
                end
            end
            bcdt_pkg::MODE_COUNTING: begin
                if (second_due) begin
                    second_due = 1'b0;
                    if (!value_is_zero()) step_down();
                    else mode_now = bcdt_pkg::MODE_ALARM;
                end
                if (st_edge) mode_now = bcdt_pkg::MODE_PAUSED;
            end
            default: begin
                if (cl_edge) mode_now = bcdt_pkg::MODE_CONFIG;
            end
        endcase

        start_was = st;
        clear_was = cl;

        f.buzz = (mode_now == bcdt_pkg::MODE_ALARM);
        f.mode = mode_now;
        f.thou = digit_val[0];
        f.hund = digit_val[1];
        f.tens = digit_val[2];
        f.ones = digit_val[3];
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            ticks_reload  = bcdt_pkg::TICKS_RESET;
            tenths_reload = bcdt_pkg::TENTHS_RESET;
            halves_reload = bcdt_pkg::HALVES_RESET;
            tick_cnt      = bcdt_pkg::TICKS_RESET;
            tenth_cnt     = bcdt_pkg::TENTHS_RESET;
            half_cnt      = bcdt_pkg::HALVES_RESET;
            half_due      = 1'b0;
            second_due    = 1'b0;
            mode_now      = bcdt_pkg::MODE_CONFIG;
            for (int i = 0; i < 4; i++) digit_val[i] = 4'd0;
            scan_pos      = 2'd0;
            start_was     = 1'b0;
            clear_was     = 1'b0;
            frames_due.delete();
        end else begin
            // oldest prediction first, a beat cannot belong to this edge's tick
            if (i_disp.valid && i_disp.ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: result beat with no prediction waiting", $time);
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("digit_enable", 8'(want.strobe), 8'(i_disp.digit_enable));
                    check_field("segments", want.seg, i_disp.segments);
                    check_field("buzzer", 8'(want.buzz), 8'(i_disp.buzzer));
                    check_field("mode", 8'(want.mode), 8'(i_disp.mode));
                    check_field("count_thousands", 8'(want.thou), 8'(i_disp.count_thousands));
                    check_field("count_hundreds", 8'(want.hund), 8'(i_disp.count_hundreds));
                    check_field("count_tens", 8'(want.tens), 8'(i_disp.count_tens));
                    check_field("count_ones", 8'(want.ones), 8'(i_disp.count_ones));
                end
            end
            // a tick on the same edge as a register write still sees the old value
            if (i_tick.valid && i_tick.ready) begin
                tick_timer(i_tick.start_level, i_tick.clear_level, i_tick.up_level,
                           i_tick.down_level, want);
                frames_due.push_back(want);
            end
            if (i_reg.valid && i_reg.ready) begin
                case (i_reg.index)
                    bcdt_pkg::REG_TICKS_PER_TENTH:   ticks_reload  = i_reg.data;
                    bcdt_pkg::REG_TENTHS_PER_HALF:   tenths_reload = i_reg.data;
                    bcdt_pkg::REG_HALVES_PER_SECOND: halves_reload = i_reg.data;
                    default: ;
                endcase
            end
        end
        o_pending    <= frames_due.size();
        o_fail_count <= errors;
    end

endmodule

/* sim/tb.sv */
// Top of the BCD countdown timer testbench: clock, reset, tick and register
// stimulus, result-side back-pressure, watchdog and verdict.
// Depends on bcdt_pkg, bcdt_if, the timer RTL and bcdt_timer_checker.
module tb;

    // button levels packed as {start, clear, up, down}
    localparam logic [3:0] BTN_NONE  = 4'b0000;
    localparam logic [3:0] BTN_START = 4'b1000;
    localparam logic [3:0] BTN_CLEAR = 4'b0100;
    localparam logic [3:0] BTN_UP    = 4'b0010;
    localparam logic [3:0] BTN_DOWN  = 4'b0001;

    // index past the last register; the block must drop writes to it
    localparam logic [bcdt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // cycles without any beat on any channel before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 4;
    localparam int PHASE_TICKS = 30;
    // a counter reloaded with zero wraps through 256 steps; a run of exactly
    // this many ticks leaves it at one, so it fires on the next tick
    localparam int ZERO_RUN    = 256;

    logic            i_clk;
    logic            i_rst_n;
    int              fail_count;
    int              pending;
    int              idle_odds;           // 1-in-N chance of an idle burst, 0 = never
    int              ticks_sent = 0;
    bcdt_pkg::t_mode shown_mode = bcdt_pkg::MODE_CONFIG;

    bcdt_in_if  tick_if ();
    bcdt_cfg_if reg_if ();
    bcdt_out_if disp_if ();

    bcd_countdown_timer_display u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .i_cfg   (reg_if),
        .o_out   (disp_if)
    );

    bcdt_timer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_if),
        .i_reg        (reg_if),
        .i_disp       (disp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mode last shown on the result side; used only to steer the block back
    // to configure mode for the last part.
    always @(posedge i_clk) begin
        if (disp_if.valid && disp_if.ready) shown_mode <= bcdt_pkg::t_mode'(disp_if.mode);
    end

    function automatic int pick_idle_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 8;
            default: return 25;
        endcase
    endfunction

    // One tick beat. valid stays high from the previous beat unless an idle
    // burst is taken, so valid never gets two assignments in one time step.
    task automatic send_tick(input logic [3:0] lv);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        tick_if.valid       <= 1'b1;
        tick_if.start_level <= lv[3];
        tick_if.clear_level <= lv[2];
        tick_if.up_level    <= lv[1];
        tick_if.down_level  <= lv[0];
        do @(posedge i_clk); while (!tick_if.ready);
        ticks_sent++;
    endtask

    // Stop sending and wait until every predicted beat has come out.
    // pending is a registered copy of the queue size, which only makes the wait longer.
    task automatic drain();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(input logic [bcdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcdt_pkg::PRE_W-1:0] val);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do @(posedge i_clk); while (!reg_if.ready);
    endtask

    // Only called with the block idle. Running counters keep their values,
    // so new settings show up at the next reload of each stage.
    task automatic program_prescaler(input logic [bcdt_pkg::PRE_W-1:0] t,
                                     input logic [bcdt_pkg::PRE_W-1:0] h,
                                     input logic [bcdt_pkg::PRE_W-1:0] s);
        put_reg(REG_SPARE, 8'($urandom));
        put_reg(bcdt_pkg::REG_TICKS_PER_TENTH, t);
        put_reg(bcdt_pkg::REG_TENTHS_PER_HALF, h);
        put_reg(bcdt_pkg::REG_HALVES_PER_SECOND, s);
        reg_if.valid <= 1'b0;
    endtask

    // Result side back-pressure: random stall bursts.
    initial begin
        int hold;
        hold = 0;
        disp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                disp_if.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                hold = $urandom_range(0, 12);
                disp_if.ready <= 1'b0;
            end else begin
                disp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((tick_if.valid && tick_if.ready) || (disp_if.valid && disp_if.ready) ||
                (reg_if.valid && reg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [bcdt_pkg::PRE_W-1:0] t, h, s;
        int                         phase_start;
        bcdt_pkg::t_mode            was;

        tick_if.valid       = 1'b0;
        tick_if.start_level = 1'b0;
        tick_if.clear_level = 1'b0;
        tick_if.up_level    = 1'b0;
        tick_if.down_level  = 1'b0;
        reg_if.valid        = 1'b0;
        reg_if.index        = '0;
        reg_if.data         = '0;
        idle_odds           = 0;
        i_rst_n             = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Run on the reset prescaler values first, so the reload at the
        // hundredth tick comes from the reset register contents.
        repeat (120) send_tick(BTN_NONE);
        drain();

        // Fastest setting: once the old counts run out, every tick raises
        // both the half-second and the one-second flag.
        program_prescaler(8'd1, 8'd1, 8'd1);
        repeat (100) send_tick(BTN_NONE);

        // ---- directed part, block in configure at 0000 with flags flowing
        idle_odds = 5;
        send_tick(BTN_START);              // start at zero stays in configure
        send_tick(BTN_NONE);
        send_tick(BTN_DOWN);               // down at zero does nothing
        send_tick(BTN_UP);
        send_tick(BTN_UP | BTN_DOWN);      // up takes the flag, down sees none
        send_tick(BTN_UP);
        send_tick(BTN_START | BTN_UP);     // enter counting, up still handled
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        send_tick(BTN_START);              // pause
        send_tick(BTN_NONE);
        send_tick(BTN_START | BTN_CLEAR);  // resume then clear in one tick
        send_tick(BTN_UP);
        send_tick(BTN_UP);
        send_tick(BTN_START);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);               // reaches zero, alarm, buzzer on
        send_tick(BTN_CLEAR);              // clear in alarm
        send_tick(BTN_UP);
        send_tick(BTN_START);
        send_tick(BTN_NONE);
        send_tick(BTN_START);              // alarm and pause in the same tick
        send_tick(BTN_CLEAR);
        send_tick(BTN_NONE);

        // ---- one period register at a time written as zero; all counters
        // sit at one here, so each run ends with the wrapped counter at one
        for (int z = 0; z < 3; z++) begin
            case (z)
                0:       begin t = 8'd0; h = 8'd1; s = 8'd1; end
                1:       begin t = 8'd1; h = 8'd0; s = 8'd1; end
                default: begin t = 8'd1; h = 8'd1; s = 8'd0; end
            endcase
            drain();
            program_prescaler(t, h, s);
            idle_odds = pick_idle_odds();
            repeat (ZERO_RUN) send_tick(4'($urandom));
        end

        // ---- random part, one prescaler setting per phase
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:  begin t = 8'd1; h = 8'd1; s = 8'd1; end
                1:  begin t = 8'd2; h = 8'd1; s = 8'd3; end
                2:  begin t = 8'd3; h = 8'd2; s = 8'd2; end
                default: begin
                    t = 8'($urandom_range(1, 4));
                    h = 8'($urandom_range(1, 4));
                    s = 8'($urandom_range(1, 4));
                end
            endcase
            drain();
            program_prescaler(t, h, s);
            idle_odds   = pick_idle_odds();
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS) begin
                if ($urandom_range(0, 3) != 0) begin
                    // set a value, start, let it run, then pause/resume/clear
                    repeat ($urandom_range(1, 24)) begin
                        send_tick(($urandom_range(0, 5) == 0) ? (BTN_UP | BTN_DOWN) : BTN_UP);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(1, 4)) send_tick(BTN_DOWN);
                    end
                    send_tick(BTN_NONE);
                    repeat ($urandom_range(1, 3)) send_tick(BTN_START);
                    repeat ($urandom_range(0, 30)) send_tick(BTN_NONE);
                    case ($urandom_range(0, 3))
                        0: begin
                            send_tick(BTN_START);
                            repeat ($urandom_range(0, 6)) send_tick(BTN_NONE);
                            case ($urandom_range(0, 2))
                                0:       send_tick(BTN_START);
                                1:       send_tick(BTN_CLEAR);
                                default: send_tick(BTN_START | BTN_CLEAR);
                            endcase
                        end
                        1:       send_tick(BTN_CLEAR);
                        default: ;
                    endcase
                    send_tick(BTN_NONE);
                    if ($urandom_range(0, 1) == 1) begin
                        send_tick(BTN_CLEAR);
                        send_tick(BTN_NONE);
                    end
                end else begin
                    // raw button noise
                    repeat ($urandom_range(1, 20)) send_tick(4'($urandom));
                end
            end
        end

        // ---- last part: no idling on either side
        drain();
        idle_odds = 0;
        program_prescaler(8'd1, 8'd1, 8'd1);

        // Back to configure from whatever mode the last phase left: pause if
        // counting (an alarm on the way is fine), then a clear edge.
        was = shown_mode;
        if (was != bcdt_pkg::MODE_CONFIG) begin
            send_tick(BTN_NONE);
            if (was == bcdt_pkg::MODE_COUNTING) begin
                send_tick(BTN_START);
                send_tick(BTN_NONE);
            end
            send_tick(BTN_CLEAR);
            send_tick(BTN_NONE);
        end

        // Set a value with flags on every tick, then count it down back to back.
        repeat (40) send_tick(BTN_UP);
        repeat (3) send_tick(BTN_UP | BTN_DOWN);
        repeat (8) send_tick(BTN_DOWN);
        send_tick(BTN_NONE);
        send_tick(BTN_START);
        repeat (5) send_tick(BTN_NONE);
        send_tick(BTN_START);
        send_tick(BTN_NONE);
        send_tick(BTN_CLEAR);
        repeat (20) send_tick(4'($urandom));

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bcdt_pkg.sv
rtl/core/bcdt_if.sv
rtl/core/bcdt_prescaler.sv
rtl/core/bcdt_display.sv
rtl/core/bcdt_mode_ctrl.sv
rtl/core/bcdt_out_buf.sv
rtl/core/bcd_countdown_timer_display.sv
sim/bcdt_timer_checker.sv
sim/tb.sv
